// ----- hdl/sscp_pkg.sv -----
// Shared types, codes and keyword table for the serial setting command parser.
`default_nettype none

package sscp_pkg;

  localparam int LINE_CAPACITY_DEFAULT = 64;

  localparam int KW_COUNT   = 4;
  localparam int KW_MAX_LEN = 10;

  // outcome codes
  localparam logic [2:0] OUT_LUM_HIGH = 3'd0;
  localparam logic [2:0] OUT_LUM_LOW  = 3'd1;
  localparam logic [2:0] OUT_TEMP     = 3'd2;
  localparam logic [2:0] OUT_OUTPUTS  = 3'd3;
  localparam logic [2:0] OUT_INVALID  = 3'd4;

  // keyword slot of SAIDAS:, the only one followed by a bit string
  localparam logic [1:0] KW_BITS_SLOT = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [6:0] {
    PH_KEY    = 7'b0000001,
    PH_SPACE  = 7'b0000010,
    PH_SIGN   = 7'b0000100,
    PH_DIGITS = 7'b0001000,
    PH_BITS   = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_FAIL   = 7'b1000000
  } phase_t;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"L", "I", "M", "_", "L", "U", "M", "_", "H", ":"},
    '{"L", "I", "M", "_", "L", "U", "M", "_", "L", ":"},
    '{"L", "I", "M", "_", "T", "E", "M", "P", ":", 8'h00},
    '{"S", "A", "I", "D", "A", "S", ":", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd10, 4'd10, 4'd9, 4'd7};

  function automatic logic kw_match(input logic [1:0] k, input logic [3:0] pos,
                                    input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (pos < KW_LEN[k]) begin
      hit = (KW_TEXT[k][pos] == c);
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/serial_setting_command_parser.sv -----
// Top level: byte-stream parser for newline-terminated setting commands.
//
// Usage: received bytes enter on the input channel (rx_byte, in_valid,
// in_stall); a beat is taken at a rising edge with in_valid high and
// in_stall low. Carriage returns are dropped. On a newline the block emits
// at most one result beat on the output channel (outcome, applied_value,
// echoed_value, out_valid, out_stall): a light or temperature limit with
// its parsed number, an outputs byte from SAIDAS:, or invalid for any other
// non-empty line. Empty lines give nothing.
//
// Timing: a byte is held in the input register and its result, if any,
// is then registered in the output register. Throughput: one byte per
// cycle while the receiver does not stall, set by the single
// parse step between the two registers (one shift-add for the decimal
// accumulator, one keyword compare per slot).
//
// Reset (rst, synchronous) empties both registers and returns the line
// state to the start of a line. While the receiver stalls, the output
// register holds its beat; the input register then fills and in_stall
// rises until the output beat is taken.
`default_nettype none

module serial_setting_command_parser import sscp_pkg::*; #(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic [2:0]              outcome,
  output logic [7:0]              applied_value,
  output logic signed [31:0]      echoed_value,
  output logic                    out_valid,
  input  wire logic               out_stall
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // line state
  logic [LEN_W-1:0] line_length,        line_length_next;
  logic [3:0]       prefix_position,    prefix_position_next;
  logic [3:0]       candidate_mask,     candidate_mask_next;
  phase_t           parse_phase,        parse_phase_next;
  logic [31:0]      number_accumulator, number_accumulator_next;
  logic             number_negative,    number_negative_next;
  logic             digit_seen,         digit_seen_next;
  logic [7:0]       bit_pattern,        bit_pattern_next;
  logic [3:0]       bit_count,          bit_count_next;
  logic             text_ended,         text_ended_next;

  // result of the byte in the input register
  logic              res_fire;
  logic [2:0]        res_outcome;
  logic [7:0]        res_applied;
  logic [31:0]       res_echoed;

  logic        advance;
  logic        out_free;
  logic [3:0]  alive;
  logic [3:0]  pos_inc;
  logic [3:0]  count_inc;
  logic [31:0] acc_times_ten;
  logic [31:0] signed_number;
  logic [1:0]  sel;
  logic        sel_found;
  logic        is_digit;
  logic        is_blank;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  assign is_digit  = (s1_byte >= CH_ZERO) && (s1_byte <= CH_NINE);
  assign is_blank  = (s1_byte == CH_SPACE) || (s1_byte == CH_TAB) ||
                     (s1_byte == CH_VT) || (s1_byte == CH_FF);
  assign pos_inc   = prefix_position + 4'd1;
  assign count_inc = bit_count + 4'd1;
  // x10 as x8 + x2, wrapping at 32 bits
  assign acc_times_ten = {number_accumulator[28:0], 3'b000} +
                         {number_accumulator[30:0], 1'b0};
  assign signed_number = number_negative ? (32'd0 - number_accumulator)
                                         : number_accumulator;

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      alive[k] = candidate_mask[k] && kw_match(2'(k), prefix_position, s1_byte);
    end
  end

  // first surviving keyword picks the command
  always_comb begin
    sel       = 2'd0;
    sel_found = 1'b0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (candidate_mask[k]) begin
        sel       = 2'(k);
        sel_found = 1'b1;
      end
    end
  end

  always_comb begin
    line_length_next        = line_length;
    prefix_position_next    = prefix_position;
    candidate_mask_next     = candidate_mask;
    parse_phase_next        = parse_phase;
    number_accumulator_next = number_accumulator;
    number_negative_next    = number_negative;
    digit_seen_next         = digit_seen;
    bit_pattern_next        = bit_pattern;
    bit_count_next          = bit_count;
    text_ended_next         = text_ended;
    res_fire    = 1'b0;
    res_outcome = OUT_INVALID;
    res_applied = 8'd0;
    res_echoed  = 32'd0;

    if (s1_byte == CH_CR) begin
      // dropped
    end else if (s1_byte == CH_LF) begin
      if (sel_found && sel != KW_BITS_SLOT && digit_seen &&
          (parse_phase == PH_DIGITS || parse_phase == PH_DONE)) begin
        res_fire    = 1'b1;
        res_outcome = {1'b0, sel};
        res_applied = signed_number[7:0];
        res_echoed  = signed_number;
      end else if (sel_found && sel == KW_BITS_SLOT && parse_phase == PH_DONE) begin
        res_fire    = 1'b1;
        res_outcome = OUT_OUTPUTS;
        res_applied = bit_pattern;
        res_echoed  = {24'd0, bit_pattern};
      end else if (line_length != '0) begin
        res_fire    = 1'b1;
        res_outcome = OUT_INVALID;
      end
      line_length_next        = '0;
      prefix_position_next    = 4'd0;
      candidate_mask_next     = 4'hF;
      parse_phase_next        = PH_KEY;
      number_accumulator_next = 32'd0;
      number_negative_next    = 1'b0;
      digit_seen_next         = 1'b0;
      bit_pattern_next        = 8'd0;
      bit_count_next          = 4'd0;
      text_ended_next         = 1'b0;
    end else if (line_length < LEN_LIMIT) begin
      line_length_next = line_length + LEN_W'(1);
      if (s1_byte == CH_NUL) begin
        text_ended_next = 1'b1;
      end else if (!text_ended) begin
        case (parse_phase)
          PH_KEY: begin
            prefix_position_next = pos_inc;
            candidate_mask_next  = alive;
            if (alive == 4'd0) begin
              parse_phase_next = PH_FAIL;
            end else begin
              for (int k = 0; k < KW_COUNT; k++) begin
                if (alive[k] && KW_LEN[k] == pos_inc) begin
                  parse_phase_next = (2'(k) == KW_BITS_SLOT) ? PH_BITS : PH_SPACE;
                end
              end
            end
          end
          PH_SPACE: begin
            if (is_blank) begin
              // skip leading whitespace
            end else if (s1_byte == CH_PLUS || s1_byte == CH_MINUS) begin
              number_negative_next = (s1_byte == CH_MINUS);
              parse_phase_next     = PH_SIGN;
            end else if (is_digit) begin
              number_accumulator_next = acc_times_ten + {28'd0, s1_byte[3:0]};
              digit_seen_next         = 1'b1;
              parse_phase_next        = PH_DIGITS;
            end else begin
              parse_phase_next = PH_FAIL;
            end
          end
          PH_SIGN, PH_DIGITS: begin
            if (is_digit) begin
              number_accumulator_next = acc_times_ten + {28'd0, s1_byte[3:0]};
              digit_seen_next         = 1'b1;
              parse_phase_next        = PH_DIGITS;
            end else begin
              parse_phase_next = (parse_phase == PH_SIGN) ? PH_FAIL : PH_DONE;
            end
          end
          PH_BITS: begin
            if (s1_byte == CH_ZERO || s1_byte == CH_ONE) begin
              bit_pattern_next = {bit_pattern[6:0], s1_byte[0]};
              bit_count_next   = count_inc;
              if (count_inc >= 4'd8) begin
                parse_phase_next = PH_DONE;
              end
            end else begin
              parse_phase_next = PH_FAIL;
            end
          end
          default: begin
            // done or failed: rest of the text is ignored
          end
        endcase
      end
    end else begin
      // overlong line: start over
      line_length_next        = '0;
      prefix_position_next    = 4'd0;
      candidate_mask_next     = 4'hF;
      parse_phase_next        = PH_KEY;
      number_accumulator_next = 32'd0;
      number_negative_next    = 1'b0;
      digit_seen_next         = 1'b0;
      bit_pattern_next        = 8'd0;
      bit_count_next          = 4'd0;
      text_ended_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length        <= '0;
      prefix_position    <= 4'd0;
      candidate_mask     <= 4'hF;
      parse_phase        <= PH_KEY;
      number_accumulator <= 32'd0;
      number_negative    <= 1'b0;
      digit_seen         <= 1'b0;
      bit_pattern        <= 8'd0;
      bit_count          <= 4'd0;
      text_ended         <= 1'b0;
    end else if (advance) begin
      line_length        <= line_length_next;
      prefix_position    <= prefix_position_next;
      candidate_mask     <= candidate_mask_next;
      parse_phase        <= parse_phase_next;
      number_accumulator <= number_accumulator_next;
      number_negative    <= number_negative_next;
      digit_seen         <= digit_seen_next;
      bit_pattern        <= bit_pattern_next;
      bit_count          <= bit_count_next;
      text_ended         <= text_ended_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_fire;
    end
    if (advance && res_fire) begin
      outcome       <= res_outcome;
      applied_value <= res_applied;
      echoed_value  <= signed'(res_echoed);
    end
  end

  // checks
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_INVALID |-> applied_value == 8'd0 && echoed_value == 32'sd0)
    else $error("invalid beat carries a non-zero value");

  a_outputs_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_OUTPUTS |-> echoed_value == signed'({24'd0, applied_value}))
    else $error("outputs echo differs from applied byte");

  a_number_low_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome <= OUT_TEMP |-> applied_value == echoed_value[7:0])
    else $error("applied byte is not the low byte of the number");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room downstream");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_LIMIT)
    else $error("line length beyond capacity");

  // first edge out of reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !s1_valid)
    else $error("registers not empty after reset");

endmodule

`default_nettype wire
